>>> rtl/core/iwt_pkg.sv
// Shared constants, types and state codes for the integer-to-word-tokens block.
// Used by iwt_bcd, iwt_speller and integer_to_word_tokens; depends on nothing.
package iwt_pkg;

   localparam int NUM_W      = 31;           // input number width
   localparam int CODE_W     = 5;            // word code width
   localparam int DIGITS     = 10;           // decimal digits of a 31-bit number
   localparam int BCD_W      = 4 * DIGITS;   // packed BCD width
   localparam int GROUPS     = 4;            // billion, million, thousand, units
   localparam int GRP_SLOTS  = 5;            // digit, Hundred, tens/teen, units, scale
   localparam int SLOTS      = GROUPS * GRP_SLOTS;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int STEP_W     = $clog2(NUM_W);
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam logic [CODE_W-1:0] WORD_ZERO     = 5'd0;
   localparam logic [CODE_W-1:0] WORD_TENS_OFS = 5'd18;
   localparam logic [CODE_W-1:0] WORD_HUNDRED  = 5'd28;
   localparam logic [CODE_W-1:0] WORD_THOUSAND = 5'd29;
   localparam logic [CODE_W-1:0] WORD_MILLION  = 5'd30;
   localparam logic [CODE_W-1:0] WORD_BILLION  = 5'd31;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CONV  = 3'b010,
      ST_SPELL = 3'b100
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bcd_stat_type;

   typedef struct packed {
      logic busy;
      logic finished;
   } spell_stat_type;

endpackage

>>> rtl/core/iwt_bcd.sv
// Iterative binary-to-BCD converter: one add-3-and-shift step per cycle.
// Depends on iwt_pkg.
module iwt_bcd (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [iwt_pkg::NUM_W-1:0]      number,
   output logic [iwt_pkg::BCD_W-1:0]      digits,
   output iwt_pkg::bcd_stat_type          stat
);

   logic [iwt_pkg::NUM_W-1:0]  bin_ff, bin_in;
   logic [iwt_pkg::BCD_W-1:0]  bcd_ff, bcd_in;
   logic [iwt_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [iwt_pkg::BCD_W-1:0]  adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int k = 0; k < iwt_pkg::DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = number;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {adj[iwt_pkg::BCD_W-2:0], bin_ff[iwt_pkg::NUM_W-1]};
         bin_in  = {bin_ff[iwt_pkg::NUM_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == iwt_pkg::STEP_W'(iwt_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign digits    = bcd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> rtl/core/iwt_speller.sv
// Word sequencer: walks the 20 word slots of the four digit groups and emits
// each present word through an output register. Depends on iwt_pkg.
module iwt_speller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [iwt_pkg::BCD_W-1:0]       digits,
   output logic                            word_valid,
   input  logic                            word_ready,
   output logic [iwt_pkg::CODE_W-1:0]      word_code,
   output logic                            word_last,
   output iwt_pkg::spell_stat_type         stat
);

   logic [iwt_pkg::BCD_W-1:0]  digits_ff, digits_in;
   logic [iwt_pkg::SLOT_W-1:0] pos_ff, pos_in;
   logic                       active_ff, active_in;
   logic                       zero_ff, zero_in;
   logic                       valid_ff, valid_in;
   logic [iwt_pkg::CODE_W-1:0] code_ff, code_in;
   logic                       last_ff, last_in;

   logic [iwt_pkg::SLOTS-1:0]  slot_ok;
   logic [iwt_pkg::CODE_W-1:0] slot_code [iwt_pkg::SLOTS];
   logic [iwt_pkg::SLOTS:0]    upto_mask;
   logic                       later;
   logic                       cur_ok;
   logic                       load_ok;
   logic                       taken;

   // per-group slot decode, billion group first
   always_comb begin
      logic [47:0]                ext;
      logic [3:0]                 h, t, u;
      logic                       above20;
      logic [iwt_pkg::CODE_W-1:0] scale;
      ext = {8'd0, digits_ff};
      for (int j = 0; j < iwt_pkg::GROUPS; j++) begin
         u = ext[(iwt_pkg::GROUPS-1-j)*12 +: 4];
         t = ext[(iwt_pkg::GROUPS-1-j)*12 + 4 +: 4];
         h = ext[(iwt_pkg::GROUPS-1-j)*12 + 8 +: 4];
         above20 = (t >= 4'd3) || ((t == 4'd2) && (u != 4'd0));
         case (j)
            0:       scale = iwt_pkg::WORD_BILLION;
            1:       scale = iwt_pkg::WORD_MILLION;
            default: scale = iwt_pkg::WORD_THOUSAND;
         endcase
         slot_ok[j*5]       = (h != 4'd0);
         slot_code[j*5]     = iwt_pkg::CODE_W'(h);
         slot_ok[j*5+1]     = (h != 4'd0);
         slot_code[j*5+1]   = iwt_pkg::WORD_HUNDRED;
         slot_ok[j*5+2]     = (t != 4'd0) || (u != 4'd0);
         slot_code[j*5+2]   = above20 ? (iwt_pkg::WORD_TENS_OFS + iwt_pkg::CODE_W'(t))
                                      : (iwt_pkg::CODE_W'(t) * 5'd10 + iwt_pkg::CODE_W'(u));
         slot_ok[j*5+3]     = above20 && (u != 4'd0);
         slot_code[j*5+3]   = iwt_pkg::CODE_W'(u);
         slot_ok[j*5+4]     = (j != iwt_pkg::GROUPS - 1) && ((h | t | u) != 4'd0);
         slot_code[j*5+4]   = scale;
      end
      // a zero number speaks the first slot, whose digit reads as Zero
      slot_ok[0] = slot_ok[0] | zero_ff;
   end

   assign upto_mask = ((iwt_pkg::SLOTS+1)'(1) << (pos_ff + 1'b1)) - 1'b1;
   assign later     = |(slot_ok & ~upto_mask[iwt_pkg::SLOTS-1:0]);
   assign cur_ok    = slot_ok[pos_ff];
   assign taken     = valid_ff & word_ready;
   assign load_ok   = !valid_ff || word_ready;

   always_comb begin
      digits_in = digits_ff;
      pos_in    = pos_ff;
      active_in = active_ff;
      zero_in   = zero_ff;
      valid_in  = taken ? 1'b0 : valid_ff;
      code_in   = code_ff;
      last_in   = last_ff;
      if (start) begin
         digits_in = digits;
         zero_in   = (digits == '0);
         pos_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (!cur_ok) begin
            pos_in = pos_ff + 1'b1;
         end else if (load_ok) begin
            valid_in = 1'b1;
            code_in  = slot_code[pos_ff];
            last_in  = !later;
            if (!later) begin
               active_in = 1'b0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      pos_ff    <= pos_in;
      zero_ff   <= zero_in;
      code_ff   <= code_in;
      last_ff   <= last_in;
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   assign word_valid    = valid_ff;
   assign word_code     = code_ff;
   assign word_last     = last_ff;
   assign stat.busy     = active_ff | valid_ff;
   assign stat.finished = taken & last_ff;

endmodule

>>> rtl/core/integer_to_word_tokens.sv
// Top level: spells a 31-bit number as a run of English word codes.
// Depends on iwt_pkg, iwt_bcd and iwt_speller.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------
//  req     | in  | req_tvalid/tready   | req_tdata[30:0] number
//  rsp     | out | rsp_tvalid/tready   | rsp_tdata[4:0] word_code, rsp_tlast
//
// A number is accepted, converted by 31 add-3-and-shift steps in the BCD
// converter and handed off to the sequencer, which walks the word slots one
// per cycle up to the last word, waiting whenever a word cannot yet enter the
// output register because the result side stalls.
// The single BCD shift unit and the one-slot-per-cycle word sequencer set the pace.
// Reset is synchronous and active high; it empties the output register and
// returns the block to idle. req_tready is high only while idle; a stalled
// result word holds in the output register and the sequencer waits on it.
module integer_to_word_tokens (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [iwt_pkg::REQ_DATA_W-1:0]      req_tdata,   // [30:0] number, [31] zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [iwt_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [4:0] word_code, [7:5] zero pad
   output logic                                rsp_tlast
);

   iwt_pkg::state_type       state_ff, state_in;
   iwt_pkg::bcd_stat_type    bcd_stat;
   iwt_pkg::spell_stat_type  spell_stat;
   logic [iwt_pkg::BCD_W-1:0]  digits;
   logic [iwt_pkg::CODE_W-1:0] word_code;
   logic                       req_take;

   assign req_tready = (state_ff == iwt_pkg::ST_IDLE);
   assign req_take   = req_tvalid & req_tready;

   // start the converter on accept; hand its digits to the sequencer when done
   iwt_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (req_take),
      .number (req_tdata[iwt_pkg::NUM_W-1:0]),
      .digits (digits),
      .stat   (bcd_stat)
   );

   iwt_speller u_speller (
      .clock      (clock),
      .reset      (reset),
      .start      (bcd_stat.done),
      .digits     (digits),
      .word_valid (rsp_tvalid),
      .word_ready (rsp_tready),
      .word_code  (word_code),
      .word_last  (rsp_tlast),
      .stat       (spell_stat)
   );

   assign rsp_tdata = {{(iwt_pkg::RSP_DATA_W - iwt_pkg::CODE_W){1'b0}}, word_code};

   // advance idle -> convert -> spell -> idle
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iwt_pkg::ST_IDLE: begin
            if (req_take) state_in = iwt_pkg::ST_CONV;
         end
         iwt_pkg::ST_CONV: begin
            if (bcd_stat.done) state_in = iwt_pkg::ST_SPELL;
         end
         iwt_pkg::ST_SPELL: begin
            if (spell_stat.finished) state_in = iwt_pkg::ST_IDLE;
         end
         default: state_in = iwt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iwt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // nothing is pending on the result side while a new number may enter
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid && !bcd_stat.busy && !spell_stat.busy))
      else $error("block ready while work is pending");

   // the converter only finishes during conversion
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      bcd_stat.done |-> (state_ff == iwt_pkg::ST_CONV))
      else $error("conversion done outside conversion state");

   // delivering the last word frees the input side on the next cycle
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("input not ready after last word");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

endmodule
